// ----- rtl/sbus_pkg.sv -----
// shared types, constants and slot tables for the sbus frame decoder
package sbus_pkg;

  // frame layout
  localparam logic [4:0]  LastPos   = 5'd24;
  localparam logic [4:0]  FlagPos   = 5'd23;
  localparam logic [7:0]  StartByte = 8'h0F;
  localparam int unsigned NumSlots  = 9;
  localparam logic [3:0]  RoverSlot = 4'd8;

  // channel scaling: (x - 172) * 1000 / 1639, reciprocal pre-multiplied by 1000
  localparam logic [10:0] SbusMin    = 11'd172;
  localparam logic [31:0] ScaleMul   = 32'd2620481000;
  localparam logic [11:0] ScaleBase  = 12'd1000;
  localparam logic [11:0] PulseMin   = 12'd800;
  localparam logic [11:0] PulseMax   = 12'd2200;
  localparam logic [11:0] RoverMin   = 12'd1000;
  localparam logic [11:0] RoverMax   = 12'd2000;
  localparam logic [11:0] InvertBase = 12'd3000;
  localparam logic [11:0] Neutral    = 12'd1500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SCALE,
    ST_MODE,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MODE_RC_DRIVE     = 3'd0,
    MODE_ESTOP        = 3'd1,
    MODE_AUTO_NO_HB   = 3'd2,
    MODE_SELF_DRIVE   = 3'd3,
    MODE_AUTO_TIMEOUT = 3'd4,
    MODE_RELAY        = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_STOP    = 2'd1,
    EV_RESTART = 2'd2
  } ppm_event_e;

  typedef enum logic [1:0] {
    REG_EMERGENCY  = 2'd0,
    REG_AUTONOMOUS = 2'd1,
    REG_RELAY_LOW  = 2'd2,
    REG_RELAY_HIGH = 2'd3
  } reg_idx_e;

  // control from the sequencer to the scaling unit
  typedef struct packed {
    logic load;
    logic rover;
    logic invert;
  } scale_ctrl_t;

  // first frame byte holding the source channel of an output slot
  function automatic logic [4:0] slot_base(logic [3:0] slot);
    logic [4:0] b;
    case (slot)
      4'd0:    b = 5'd3;
      4'd1:    b = 5'd1;
      4'd2:    b = 5'd6;
      4'd3:    b = 5'd7;
      4'd4:    b = 5'd14;
      4'd5:    b = 5'd16;
      4'd6:    b = 5'd9;
      4'd7:    b = 5'd10;
      4'd8:    b = 5'd12;
      default: b = 5'd1;
    endcase
    return b;
  endfunction

  // bit offset of the source channel inside its first byte
  function automatic logic [2:0] slot_shift(logic [3:0] slot);
    logic [2:0] s;
    case (slot)
      4'd0:    s = 3'd6;
      4'd1:    s = 3'd0;
      4'd2:    s = 3'd4;
      4'd3:    s = 3'd7;
      4'd4:    s = 3'd6;
      4'd5:    s = 3'd1;
      4'd6:    s = 3'd2;
      4'd7:    s = 3'd5;
      4'd8:    s = 3'd0;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // outputs driven as 3000 - v
  function automatic logic slot_inverted(logic [3:0] slot);
    logic inv;
    case (slot)
      4'd1, 4'd2, 4'd3, 4'd6, 4'd7: inv = 1'b1;
      default:                      inv = 1'b0;
    endcase
    return inv;
  endfunction

  // accepted end-of-frame bytes
  function automatic logic end_byte_ok(logic [7:0] b);
    logic ok;
    case (b) inside
      8'h00, 8'h04, 8'h14, 8'h24, 8'h34: ok = 1'b1;
      default:                          ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ----- rtl/sbus_frame_to_ppm_channels.sv -----
// sbus frame decoder top level: byte assembly, decode sequencer, mode logic and result output
// each byte transaction is taken while the decoder is idle.
// a good end byte starts a decode of the nine channels, each with three ram byte reads,
// one multiply and one scale, then a mode evaluation. the nine results then leave at up to
// one per cycle while the output is ready; input is taken again after the ninth.
// reset clears the byte position, failsafe latch, sequencer and thresholds (1700/1700/1250/1750);
// the frame ram is not cleared, every byte of a frame is written before it is read.
module sbus_frame_to_ppm_channels import sbus_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        idle_gap_i,
  input  logic        heartbeat_alive_i,
  input  logic        command_fresh_i,
  input  logic [11:0] auto_throttle_i,
  input  logic [11:0] auto_steering_i,
  // channel results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  channel_index_o,
  output logic [11:0] channel_value_o,
  output logic [2:0]  mode_o,
  output logic        link_lost_o,
  output logic        failsafe_o,
  output logic [1:0]  ppm_event_o,
  output logic        last_o
);

  state_e      state_q, state_d;
  logic [4:0]  pos_q, pos_d;
  logic [3:0]  slot_q, slot_d;
  logic [1:0]  rd_cnt_q, rd_cnt_d;
  logic [3:0]  emit_q, emit_d;
  logic [23:0] acc_q, acc_d;
  logic [7:0]  flag_byte_q, flag_byte_d;
  logic        hb_q, hb_d;
  logic        fresh_q, fresh_d;
  logic [11:0] thr_q, thr_d;
  logic [11:0] ste_q, ste_d;
  logic        fs_latched_q, fs_latched_d;
  logic [11:0] emer_thr_q, emer_thr_d;
  logic [11:0] auto_thr_q, auto_thr_d;
  logic [10:0] relay_low_q, relay_low_d;
  logic [10:0] relay_high_q, relay_high_d;
  logic [11:0] ppm_q [NumSlots];
  logic [11:0] ppm_d [NumSlots];
  mode_e       mode_q, mode_d;
  ppm_event_e  ev_q, ev_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_idx_q, out_idx_d;
  logic [11:0] out_val_q, out_val_d;
  mode_e       out_mode_q, out_mode_d;
  logic        out_lost_q, out_lost_d;
  logic        out_fs_q, out_fs_d;
  ppm_event_e  out_ev_q, out_ev_d;
  logic        out_last_q, out_last_d;

  logic        accept;
  logic [4:0]  eff_pos;
  logic        store;
  logic [4:0]  raddr;
  logic [7:0]  rdata;
  logic [23:0] shifted;
  logic [10:0] raw;
  scale_ctrl_t scale_ctrl;
  logic [11:0] scale_value;
  logic        out_free;
  logic        fs_now;

  function automatic logic [11:0] clamp_pulse(logic [11:0] v);
    logic [11:0] r;
    r = (v < PulseMin) ? PulseMin : ((v > PulseMax) ? PulseMax : v);
    return r;
  endfunction

  // frame byte store
  sbus_ram #(
    .Width(8),
    .Depth(25)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (store),
    .waddr_i(eff_pos),
    .wdata_i(rx_byte_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // shared scaling unit
  sbus_scale u_scale (
    .clk_i  (clk_i),
    .ctrl_i (scale_ctrl),
    .raw_i  (raw),
    .value_o(scale_value)
  );

  // byte handshake and frame position
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    accept     = in_valid_i && in_ready_o;
    eff_pos    = idle_gap_i ? 5'd0 : pos_q;
    store      = accept && !((eff_pos == 5'd0) && (rx_byte_i != StartByte));
    raddr      = slot_base(slot_q) + {3'b000, rd_cnt_q};
    shifted    = acc_q >> slot_shift(slot_q);
    raw        = shifted[10:0];
    out_free   = !out_valid_q || out_ready_i;
    fs_now     = flag_byte_q[3];
  end

  // configuration writes
  always_comb begin
    emer_thr_d   = emer_thr_q;
    auto_thr_d   = auto_thr_q;
    relay_low_d  = relay_low_q;
    relay_high_d = relay_high_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EMERGENCY:  emer_thr_d   = cfg_wdata_i;
        REG_AUTONOMOUS: auto_thr_d   = cfg_wdata_i;
        REG_RELAY_LOW:  relay_low_d  = cfg_wdata_i[10:0];
        REG_RELAY_HIGH: relay_high_d = cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // decode sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    slot_d       = slot_q;
    rd_cnt_d     = rd_cnt_q;
    emit_d       = emit_q;
    acc_d        = acc_q;
    flag_byte_d  = flag_byte_q;
    hb_d         = hb_q;
    fresh_d      = fresh_q;
    thr_d        = thr_q;
    ste_d        = ste_q;
    fs_latched_d = fs_latched_q;
    ppm_d        = ppm_q;
    mode_d       = mode_q;
    ev_d         = ev_q;
    scale_ctrl   = '{load: 1'b0, rover: (slot_q == RoverSlot), invert: slot_inverted(slot_q)};

    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_mode_d  = out_mode_q;
    out_lost_d  = out_lost_q;
    out_fs_d    = out_fs_q;
    out_ev_d    = out_ev_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          hb_d    = heartbeat_alive_i;
          fresh_d = command_fresh_i;
          thr_d   = auto_throttle_i;
          ste_d   = auto_steering_i;
          if (!store) begin
            pos_d = 5'd0;
          end else if (eff_pos == LastPos) begin
            pos_d = 5'd0;
            if (end_byte_ok(rx_byte_i)) begin
              slot_d   = 4'd0;
              rd_cnt_d = 2'd0;
              state_d  = ST_READ;
            end
          end else begin
            pos_d = eff_pos + 5'd1;
          end
          if (store && (eff_pos == FlagPos)) begin
            flag_byte_d = rx_byte_i;
          end
        end
      end
      ST_READ: begin
        // three byte reads, data lands in the cycle after each address
        case (rd_cnt_q)
          2'd1:    acc_d[7:0]   = rdata;
          2'd2:    acc_d[15:8]  = rdata;
          2'd3:    acc_d[23:16] = rdata;
          default: ;
        endcase
        rd_cnt_d = rd_cnt_q + 2'd1;
        if (rd_cnt_q == 2'd3) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        scale_ctrl.load = 1'b1;
        state_d         = ST_SCALE;
      end
      ST_SCALE: begin
        ppm_d[slot_q] = scale_value;
        if (slot_q == RoverSlot) begin
          state_d = ST_MODE;
        end else begin
          slot_d   = slot_q + 4'd1;
          rd_cnt_d = 2'd0;
          state_d  = ST_READ;
        end
      end
      ST_MODE: begin
        // drive mode priority: emergency, autonomous branch, relay, manual
        if (ppm_q[2] < emer_thr_q) begin
          mode_d = MODE_ESTOP;
        end else if (ppm_q[3] > auto_thr_q) begin
          if (!hb_q) begin
            mode_d = MODE_AUTO_NO_HB;
          end else if (fresh_q) begin
            mode_d = MODE_SELF_DRIVE;
          end else begin
            mode_d = MODE_AUTO_TIMEOUT;
          end
        end else if ((ppm_q[8] > {1'b0, relay_low_q}) && (ppm_q[8] <= {1'b0, relay_high_q})) begin
          mode_d = MODE_RELAY;
        end else begin
          mode_d = MODE_RC_DRIVE;
        end
        // throttle and steering overrides
        if (mode_d == MODE_SELF_DRIVE) begin
          ppm_d[0] = clamp_pulse(thr_q);
          ppm_d[1] = clamp_pulse(ste_q);
        end else if (mode_d != MODE_RC_DRIVE) begin
          ppm_d[0] = Neutral;
          ppm_d[1] = Neutral;
        end
        // failsafe edge detection
        if (fs_now && !fs_latched_q) begin
          fs_latched_d = 1'b1;
          ev_d         = EV_STOP;
        end else if (!fs_now && fs_latched_q) begin
          fs_latched_d = 1'b0;
          ev_d         = EV_RESTART;
        end else begin
          ev_d = EV_NONE;
        end
        emit_d  = 4'd0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = emit_q;
          out_val_d   = ppm_q[emit_q];
          out_mode_d  = mode_q;
          out_lost_d  = flag_byte_q[2];
          out_fs_d    = fs_now;
          out_ev_d    = ev_q;
          out_last_d  = (emit_q == RoverSlot);
          emit_d      = emit_q + 4'd1;
          if (emit_q == RoverSlot) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= 5'd0;
      slot_q       <= 4'd0;
      rd_cnt_q     <= 2'd0;
      emit_q       <= 4'd0;
      fs_latched_q <= 1'b0;
      out_valid_q  <= 1'b0;
      emer_thr_q   <= 12'd1700;
      auto_thr_q   <= 12'd1700;
      relay_low_q  <= 11'd1250;
      relay_high_q <= 11'd1750;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      slot_q       <= slot_d;
      rd_cnt_q     <= rd_cnt_d;
      emit_q       <= emit_d;
      fs_latched_q <= fs_latched_d;
      out_valid_q  <= out_valid_d;
      emer_thr_q   <= emer_thr_d;
      auto_thr_q   <= auto_thr_d;
      relay_low_q  <= relay_low_d;
      relay_high_q <= relay_high_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    flag_byte_q <= flag_byte_d;
    hb_q        <= hb_d;
    fresh_q     <= fresh_d;
    thr_q       <= thr_d;
    ste_q       <= ste_d;
    ppm_q       <= ppm_d;
    mode_q      <= mode_d;
    ev_q        <= ev_d;
    out_idx_q   <= out_idx_d;
    out_val_q   <= out_val_d;
    out_mode_q  <= out_mode_d;
    out_lost_q  <= out_lost_d;
    out_fs_q    <= out_fs_d;
    out_ev_q    <= out_ev_d;
    out_last_q  <= out_last_d;
  end

  // result ports
  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign mode_o          = out_mode_q;
  assign link_lost_o     = out_lost_q;
  assign failsafe_o      = out_fs_q;
  assign ppm_event_o     = out_ev_q;
  assign last_o          = out_last_q;

  // the final result of a frame always carries the rover select index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> channel_index_o == RoverSlot)
    else $error("last result without rover select index");

  // a stop event can only go with failsafe set, a restart only with it clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ppm_event_o == EV_STOP) |-> failsafe_o)
    else $error("stop event without failsafe");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ppm_event_o == EV_RESTART) |-> !failsafe_o)
    else $error("restart event with failsafe set");

  // every emitted pulse width lies in the legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (channel_value_o >= PulseMin) && (channel_value_o <= PulseMax))
    else $error("pulse width out of range");

  // the byte position stays inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("byte position past end of frame");

  // mode evaluation only follows the rover select channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MODE |-> $past(state_q) == ST_SCALE && slot_q == RoverSlot)
    else $error("mode evaluated before all channels scaled");

endmodule

// ----- rtl/sbus_ram.sv -----
// generic single write, single read ram with registered read data
module sbus_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 25,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sbus_scale.sv -----
// shared channel scaling unit: reciprocal multiply, then offset, clamp and inversion
module sbus_scale import sbus_pkg::*; (
  input  logic        clk_i,
  input  scale_ctrl_t ctrl_i,
  input  logic [10:0] raw_i,
  output logic [11:0] value_o
);

  logic [11:0] diff;
  logic [11:0] mag_full;
  logic [42:0] prod;
  logic [10:0] quot_q, quot_d;
  logic        neg_q, neg_d;
  logic [11:0] sum;
  logic [11:0] lo, hi;
  logic [11:0] clamped;

  // signed distance from the sbus minimum and its magnitude
  always_comb begin
    diff     = {1'b0, raw_i} - {1'b0, SbusMin};
    mag_full = diff[11] ? (12'd0 - diff) : diff;
    prod     = 43'(mag_full[10:0]) * 43'(ScaleMul);
    quot_d   = prod[42:32];
    neg_d    = diff[11];
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      quot_q <= quot_d;
      neg_q  <= neg_d;
    end
  end

  // truncation toward zero, offset, clamp and inversion
  always_comb begin
    sum     = neg_q ? (ScaleBase - {1'b0, quot_q}) : (ScaleBase + {1'b0, quot_q});
    lo      = ctrl_i.rover ? RoverMin : PulseMin;
    hi      = ctrl_i.rover ? RoverMax : PulseMax;
    clamped = (sum < lo) ? lo : ((sum > hi) ? hi : sum);
    value_o = ctrl_i.invert ? (InvertBase - clamped) : clamped;
  end

endmodule

// ----- sim/tb_sbus_frame_to_ppm_channels.sv -----
// self-checking testbench for the sbus frame decoder with its channel predictor
module tb_sbus_frame_to_ppm_channels import sbus_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameBytes = 25;

  // one byte transaction with the host inputs that travel with it
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        idle_gap;
    logic        heartbeat_alive;
    logic        command_fresh;
    logic [11:0] auto_throttle;
    logic [11:0] auto_steering;
  } sbus_byte_t;

  // one channel result transaction
  typedef struct packed {
    logic [3:0]  channel_index;
    logic [11:0] channel_value;
    logic [2:0]  mode;
    logic        link_lost;
    logic        failsafe;
    logic [1:0]  ppm_event;
    logic        last;
  } channel_result_t;

  // frame assembly and channel decode predictor, plus the queue of channels still due
  class channel_scoreboard;
    logic [7:0]      rx_frame[FrameBytes];
    int              fill_count;
    logic            fs_held;
    int              emer_thr;
    int              auto_thr;
    int              relay_lo;
    int              relay_hi;
    channel_result_t channels_due[$];
    int              errors;

    function new();
      foreach (rx_frame[i]) rx_frame[i] = '0;
      fill_count = 0;
      fs_held    = 1'b0;
      emer_thr   = 1700;
      auto_thr   = 1700;
      relay_lo   = 1250;
      relay_hi   = 1750;
      errors     = 0;
    endfunction

    function int pending();
      return channels_due.size();
    endfunction

    function int limit(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // raw 11-bit stick value to microseconds, division truncates toward zero
    function int to_pulse(logic [10:0] raw);
      int d;
      d = int'(raw) - int'(SbusMin);
      return d * 1000 / 1639 + int'(ScaleBase);
    endfunction

    function void set_register(reg_idx_e idx, logic [11:0] val);
      case (idx)
        REG_EMERGENCY:  emer_thr = int'(val);
        REG_AUTONOMOUS: auto_thr = int'(val);
        REG_RELAY_LOW:  relay_lo = int'(val[10:0]);
        REG_RELAY_HIGH: relay_hi = int'(val[10:0]);
        default: ;
      endcase
    endfunction

    function void note_byte(sbus_byte_t b);
      int              src[8];
      logic [7:0]      inv_mask;
      logic [175:0]    payload;
      int              pulse[9];
      mode_e           md;
      ppm_event_e      ev;
      logic            fs;
      channel_result_t r;
      src      = '{2, 0, 4, 5, 10, 11, 6, 7};
      inv_mask = 8'hCE;

      // frame assembly: a gap restarts, only the start byte opens a frame
      if (b.idle_gap) fill_count = 0;
      if (fill_count >= FrameBytes) fill_count = 0;
      if (fill_count == 0 && b.rx_byte != StartByte) return;
      rx_frame[fill_count] = b.rx_byte;
      fill_count++;
      if (fill_count < FrameBytes) return;
      fill_count = 0;
      if (!(rx_frame[FrameBytes - 1] inside {8'h00, 8'h04, 8'h14, 8'h24, 8'h34})) return;

      // unpack, scale, clamp and invert the eight ppm outputs and rover select
      for (int i = 0; i < 22; i++) payload[8*i +: 8] = rx_frame[i + 1];
      for (int i = 0; i < 8; i++) begin
        pulse[i] = limit(to_pulse(payload[11*src[i] +: 11]), PulseMin, PulseMax);
        if (inv_mask[i]) pulse[i] = int'(InvertBase) - pulse[i];
      end
      pulse[8] = limit(to_pulse(payload[88 +: 11]), RoverMin, RoverMax);

      // drive mode selection
      if (pulse[2] < emer_thr) begin
        md = MODE_ESTOP;
      end else if (pulse[3] > auto_thr) begin
        if (!b.heartbeat_alive) md = MODE_AUTO_NO_HB;
        else if (b.command_fresh) md = MODE_SELF_DRIVE;
        else md = MODE_AUTO_TIMEOUT;
      end else if (pulse[8] > relay_lo && pulse[8] <= relay_hi) begin
        md = MODE_RELAY;
      end else begin
        md = MODE_RC_DRIVE;
      end

      // throttle and steering overrides
      if (md == MODE_SELF_DRIVE) begin
        pulse[0] = limit(int'(b.auto_throttle), PulseMin, PulseMax);
        pulse[1] = limit(int'(b.auto_steering), PulseMin, PulseMax);
      end else if (md != MODE_RC_DRIVE) begin
        pulse[0] = Neutral;
        pulse[1] = Neutral;
      end

      // failsafe edges
      fs = rx_frame[23][3];
      ev = EV_NONE;
      if (fs && !fs_held) ev = EV_STOP;
      else if (!fs && fs_held) ev = EV_RESTART;
      fs_held = fs;

      for (int i = 0; i < 9; i++) begin
        r.channel_index = 4'(i);
        r.channel_value = 12'(pulse[i]);
        r.mode          = md;
        r.link_lost     = rx_frame[23][2];
        r.failsafe      = fs;
        r.ppm_event     = ev;
        r.last          = (i == 8);
        channels_due.push_back(r);
      end
    endfunction

    function void check_result(channel_result_t got, time stamp);
      channel_result_t want;
      int unsigned     want_f[7];
      int unsigned     got_f[7];
      string           fname[7];
      if (channels_due.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual index %0d value %0d",
                 stamp, got.channel_index, got.channel_value);
        errors++;
        return;
      end
      want   = channels_due.pop_front();
      fname  = '{"channel_index", "channel_value", "mode", "link_lost", "failsafe",
                 "ppm_event", "last"};
      want_f = '{want.channel_index, want.channel_value, want.mode, want.link_lost,
                 want.failsafe, want.ppm_event, want.last};
      got_f  = '{got.channel_index, got.channel_value, got.mode, got.link_lost,
                 got.failsafe, got.ppm_event, got.last};
      foreach (fname[i]) begin
        if (want_f[i] != got_f[i]) begin
          $display("%0t ns: %s mismatch on index %0d, expected %0d actual %0d",
                   stamp, fname[i], want.channel_index, want_f[i], got_f[i]);
          errors++;
        end
      end
    endfunction
  endclass

  localparam int DrainCycles = 80;
  localparam int TailCycles  = 100;
  localparam int PhaseBytes  = 40;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        cfg_we          = 1'b0;
  logic [1:0]  cfg_idx         = REG_EMERGENCY;
  logic [11:0] cfg_wdata       = '0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte         = '0;
  logic        idle_gap        = 1'b0;
  logic        heartbeat_alive = 1'b0;
  logic        command_fresh   = 1'b0;
  logic [11:0] auto_throttle   = '0;
  logic [11:0] auto_steering   = '0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [3:0]  channel_index;
  logic [11:0] channel_value;
  logic [2:0]  mode;
  logic        link_lost;
  logic        failsafe;
  logic [1:0]  ppm_event;
  logic        last;

  channel_scoreboard channels;
  logic              in_idle_on  = 1'b1;
  logic              out_idle_on = 1'b1;
  logic              restart_gap = 1'b0;
  logic [10:0]       chan[16];
  int                bytes_sent  = 0;
  int                frames_built = 0;

  sbus_frame_to_ppm_channels u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .rx_byte_i         (rx_byte),
    .idle_gap_i        (idle_gap),
    .heartbeat_alive_i (heartbeat_alive),
    .command_fresh_i   (command_fresh),
    .auto_throttle_i   (auto_throttle),
    .auto_steering_i   (auto_steering),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .channel_index_o   (channel_index),
    .channel_value_o   (channel_value),
    .mode_o            (mode),
    .link_lost_o       (link_lost),
    .failsafe_o        (failsafe),
    .ppm_event_o       (ppm_event),
    .last_o            (last)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("[sbus_frame_to_ppm_channels] ERROR");
    $finish;
  end

  // host pulse width, mostly in range, sometimes anywhere in the field
  function automatic logic [11:0] host_pulse();
    if ($urandom_range(0, 7) == 0) return 12'($urandom_range(0, 4095));
    return 12'($urandom_range(800, 2200));
  endfunction

  function automatic sbus_byte_t with_host_inputs(logic [7:0] v);
    sbus_byte_t b;
    b.rx_byte         = v;
    b.idle_gap        = 1'b0;
    b.heartbeat_alive = 1'($urandom_range(0, 1));
    b.command_fresh   = 1'($urandom_range(0, 1));
    b.auto_throttle   = host_pulse();
    b.auto_steering   = host_pulse();
    return b;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [11:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    channels.set_register(idx, val);
  endtask

  // one byte transaction, with a random pause in front while input idles are enabled
  task automatic send_byte(sbus_byte_t b);
    int unsigned pause;
    pause = in_idle_on ? $urandom_range(0, 4) : 0;
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid        <= 1'b1;
    rx_byte         <= b.rx_byte;
    idle_gap        <= b.idle_gap;
    heartbeat_alive <= b.heartbeat_alive;
    command_fresh   <= b.command_fresh;
    auto_throttle   <= b.auto_throttle;
    auto_steering   <= b.auto_steering;
    do @(posedge clk); while (!in_ready);
    channels.note_byte(b);
    bytes_sent++;
  endtask

  // first count bytes of a frame built from chan, the host inputs given ride on the tail
  task automatic send_frame(int count, logic [7:0] flag, logic [7:0] tail, logic hb,
                            logic fresh, logic [11:0] thr, logic [11:0] ste);
    logic [175:0] payload;
    logic [7:0]   fb[FrameBytes];
    sbus_byte_t   b;
    for (int k = 0; k < 16; k++) payload[11*k +: 11] = chan[k];
    fb[0] = StartByte;
    for (int i = 1; i <= 22; i++) fb[i] = payload[8*(i-1) +: 8];
    fb[23] = flag;
    fb[24] = tail;
    for (int i = 0; i < count; i++) begin
      b = with_host_inputs(fb[i]);
      if (i == 0) b.idle_gap = restart_gap | 1'($urandom_range(0, 1));
      if (i == FrameBytes - 1) begin
        b.heartbeat_alive = hb;
        b.command_fresh   = fresh;
        b.auto_throttle   = thr;
        b.auto_steering   = ste;
      end
      send_byte(b);
    end
    restart_gap = (count < FrameBytes);
  endtask

  // mostly good frames aimed at each mode in turn, with noise, short and bad-tail frames
  task automatic run_random(int budget);
    int         first;
    mode_e      target;
    logic       hb;
    logic       fresh;
    logic [7:0] good_tails[5];
    sbus_byte_t b;
    first      = bytes_sent;
    good_tails = '{8'h00, 8'h04, 8'h14, 8'h24, 8'h34};
    while (bytes_sent - first < budget) begin
      for (int k = 0; k < 16; k++) chan[k] = 11'($urandom_range(0, 2047));
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 3)) begin
            b = with_host_inputs(8'($urandom_range(0, 255)));
            b.idle_gap = 1'($urandom_range(0, 1));
            send_byte(b);
          end
          restart_gap = 1'b1;
        end
        1: begin
          send_frame($urandom_range(1, FrameBytes - 1), 8'($urandom_range(0, 255)),
                     8'h00, 1'b1, 1'b1, host_pulse(), host_pulse());
        end
        2: begin
          // every good tail is even, so an odd tail is always rejected
          send_frame(FrameBytes, 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)) | 8'h01, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), host_pulse(), host_pulse());
        end
        default: begin
          target = mode_e'(frames_built % 6);
          frames_built++;
          chan[4] = (target == MODE_ESTOP) ? 11'($urandom_range(1500, 2047))
                                           : 11'($urandom_range(0, 600));
          chan[5] = (target inside {MODE_AUTO_NO_HB, MODE_SELF_DRIVE, MODE_AUTO_TIMEOUT})
                    ? 11'($urandom_range(0, 600)) : 11'($urandom_range(1500, 2047));
          if (target == MODE_RELAY) chan[8] = 11'($urandom_range(600, 1100));
          else if ($urandom_range(0, 1) == 1) chan[8] = 11'($urandom_range(0, 300));
          else chan[8] = 11'($urandom_range(1500, 2047));
          hb    = (target == MODE_AUTO_NO_HB) ? 1'b0
                : (target inside {MODE_SELF_DRIVE, MODE_AUTO_TIMEOUT}) ? 1'b1
                : 1'($urandom_range(0, 1));
          fresh = (target == MODE_SELF_DRIVE) ? 1'b1
                : (target == MODE_AUTO_TIMEOUT) ? 1'b0
                : 1'($urandom_range(0, 1));
          send_frame(FrameBytes, 8'($urandom_range(0, 255)),
                     good_tails[$urandom_range(0, 4)], hb, fresh, host_pulse(), host_pulse());
        end
      endcase
    end
  endtask

  // drop valid, wait for every channel due, then let the decoder settle
  task automatic wait_decoder_idle(int cycles);
    in_valid <= 1'b0;
    while (channels.pending() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // result sink with random back-pressure while output idles are enabled
  initial begin : result_sink
    int unsigned     stall;
    channel_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got.channel_index = channel_index;
      got.channel_value = channel_value;
      got.mode          = mode;
      got.link_lost     = link_lost;
      got.failsafe      = failsafe;
      got.ppm_event     = ppm_event;
      got.last          = last;
      channels.check_result(got, $time);
    end
  end

  // reset, directed frames, then random phases over several register settings
  initial begin : stimulus
    sbus_byte_t b;
    channels = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bad start bytes, all zeros and all ones, the second behind a gap
    b = '0;
    send_byte(b);
    b = '1;
    send_byte(b);

    // short frame cut off by a gap
    for (int k = 0; k < 16; k++) chan[k] = 11'($urandom_range(0, 2047));
    send_frame(4, 8'h00, 8'h00, 1'b0, 1'b0, 12'd1500, 12'd1500);

    // full frame of raw extremes, autonomous with out-of-range host values
    for (int k = 0; k < 16; k++) chan[k] = k[0] ? 11'h000 : 11'h7FF;
    chan[4] = 11'h000;
    send_frame(FrameBytes, 8'hFF, 8'h34, 1'b1, 1'b1, 12'hFFF, 12'h000);

    for (int phase = 0; phase < 5; phase++) begin
      wait_decoder_idle(DrainCycles);
      in_idle_on  = (phase != 1);
      out_idle_on = (phase != 3);
      case (phase)
        1: begin
          write_reg(REG_EMERGENCY, 12'd800);
          write_reg(REG_AUTONOMOUS, 12'd800);
          write_reg(REG_RELAY_LOW, 12'd1000);
          write_reg(REG_RELAY_HIGH, 12'd1000);
        end
        2: begin
          write_reg(REG_EMERGENCY, 12'd2200);
          write_reg(REG_AUTONOMOUS, 12'd2200);
          write_reg(REG_RELAY_LOW, 12'd2000);
          write_reg(REG_RELAY_HIGH, 12'd2000);
        end
        3: begin
          write_reg(REG_EMERGENCY, 12'($urandom_range(800, 2200)));
          write_reg(REG_AUTONOMOUS, 12'($urandom_range(800, 2200)));
          write_reg(REG_RELAY_LOW, 12'($urandom_range(1000, 2000)));
          write_reg(REG_RELAY_HIGH, 12'($urandom_range(1000, 2000)));
        end
        4: begin
          write_reg(REG_EMERGENCY, 12'd1700);
          write_reg(REG_AUTONOMOUS, 12'd1700);
          write_reg(REG_RELAY_LOW, 12'd1250);
          write_reg(REG_RELAY_HIGH, 12'd1750);
        end
        default: ;
      endcase
      run_random(PhaseBytes);
    end

    wait_decoder_idle(TailCycles);
    if (channels.errors == 0 && channels.pending() == 0) begin
      $display("[sbus_frame_to_ppm_channels] OK");
    end else begin
      $display("[sbus_frame_to_ppm_channels] ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sbus_pkg.sv
rtl/sbus_ram.sv
rtl/sbus_scale.sv
rtl/sbus_frame_to_ppm_channels.sv
sim/tb_sbus_frame_to_ppm_channels.sv
